// ----- hdl/bxg_pkg.sv -----
package bxg_pkg;

   // Field width of every operand and result
   localparam int WIDTH = 31;
   // Working width: one bit for a sum of two terms, one more of headroom
   localparam int IW = WIDTH + 2;
   // Enough bits to count the stripped factors of two (at most WIDTH-1)
   localparam int KW = $clog2(WIDTH);

   typedef struct packed {
      logic [WIDTH-1:0] first_value;
      logic [WIDTH-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic [WIDTH-1:0] coef_a;
      logic [WIDTH-1:0] coef_b;
      logic [WIDTH-1:0] gcd_value;
      logic [WIDTH-1:0] larger_value;
      logic [WIDTH-1:0] smaller_value;
   } rsp_type;

   // One value per lane of the shared unit
   typedef struct packed {
      logic [IW-1:0] a;
      logic [IW-1:0] b;
      logic [IW-1:0] g;
   } opnd_type;

   // Borrow out of each lane on a subtract (x less than y)
   typedef struct packed {
      logic borrow_a;
      logic borrow_b;
      logic borrow_g;
   } flags_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   localparam logic [IW-1:0] ONE = IW'(1);

endpackage

// ----- hdl/binary_extended_gcd.sv -----
// Channel   Ports                         Handshake
// --------  ----------------------------  ---------------------------------
// request   start, busy, req_data         taken when start && !busy
// result    rsp_strobe, rsp_data          one cycle per result, no back-off
//
// One request is captured, the common factors of two are stripped, then
// a data-dependent run of the extended iteration follows (each step
// a single pass through the shared add/subtract unit), then the final
// reduction, the left shift that restores the stripped factors and the
// result. busy stays high from acceptance to the strobe.
// Reset is synchronous and returns the sequencer to idle. The receiver
// cannot stall: the result is presented for exactly one cycle.
module binary_extended_gcd (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bxg_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bxg_pkg::rsp_type rsp_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_STRIP   = 9'b000000010,
      ST_HALVE   = 9'b000000100,
      ST_SWAPCHK = 9'b000001000,
      ST_FIX     = 9'b000010000,
      ST_ADDFIX  = 9'b000100000,
      ST_REDUCE  = 9'b001000000,
      ST_SHIFT   = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [bxg_pkg::WIDTH-1:0] big_ff, big_in;
   logic [bxg_pkg::WIDTH-1:0] small_ff, small_in;
   logic [bxg_pkg::KW-1:0]    k_ff, k_in;

   // Working triple (a, b, g) and its partner (ta, tb, tg)
   bxg_pkg::opnd_type cur_ff, cur_in;
   bxg_pkg::opnd_type tmp_ff, tmp_in;

   // Shared add/subtract unit
   bxg_pkg::alu_op_type alu_op;
   bxg_pkg::opnd_type   alu_x;
   bxg_pkg::opnd_type   alu_y;
   bxg_pkg::opnd_type   alu_res;
   bxg_pkg::flags_type  alu_flags;

   logic [bxg_pkg::IW-1:0] big_ext;
   logic [bxg_pkg::IW-1:0] small_ext;
   logic [bxg_pkg::IW-1:0] next_g;

   assign big_ext   = bxg_pkg::IW'(big_ff);
   assign small_ext = bxg_pkg::IW'(small_ff);

   bxg_alu u_alu (
      .op    (alu_op),
      .x     (alu_x),
      .y     (alu_y),
      .res   (alu_res),
      .flags (alu_flags)
   );

   // Operand steering: the working triple is the left operand, except
   // while stripping, where the unit forms big - 1 for the partner seed.
   always_comb begin
      alu_op = bxg_pkg::ALU_SUB;
      alu_x  = cur_ff;
      alu_y  = tmp_ff;
      case (state_ff)
         ST_STRIP: begin
            alu_x.b = big_ext;
            alu_y.b = bxg_pkg::ONE;
         end
         ST_HALVE, ST_ADDFIX: begin
            alu_op  = bxg_pkg::ALU_ADD;
            alu_y.a = small_ext;
            alu_y.b = big_ext;
            alu_y.g = '0;
         end
         ST_REDUCE: begin
            alu_y.a = small_ext;
            alu_y.b = big_ext;
            alu_y.g = '0;
         end
         default: begin
            alu_op = bxg_pkg::ALU_SUB;
         end
      endcase
   end

   // g after a possible swap decides whether the inner loop goes round again
   assign next_g = (!tmp_ff.g[0] || alu_flags.borrow_g) ? tmp_ff.g : cur_ff.g;

   always_comb begin
      state_in = state_ff;
      big_in   = big_ff;
      small_in = small_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      tmp_in   = tmp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // order the pair so that the first is not smaller
               if (req_data.first_value < req_data.second_value) begin
                  big_in   = req_data.second_value;
                  small_in = req_data.first_value;
               end else begin
                  big_in   = req_data.first_value;
                  small_in = req_data.second_value;
               end
               k_in     = '0;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (small_ff == '0) begin
               // zero smaller operand: no iteration, gcd is the larger one
               cur_in.a = bxg_pkg::ONE;
               cur_in.b = '0;
               cur_in.g = big_ext;
               state_in = ST_SHIFT;
            end else if (!big_ff[0] && !small_ff[0]) begin
               big_in   = big_ff >> 1;
               small_in = small_ff >> 1;
               k_in     = k_ff + bxg_pkg::KW'(1);
            end else begin
               cur_in.a = bxg_pkg::ONE;
               cur_in.b = '0;
               cur_in.g = big_ext;
               tmp_in.a = small_ext;
               tmp_in.b = alu_res.b;
               tmp_in.g = small_ext;
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            // halve an even g, first making a and b even if needed
            if (!cur_ff.g[0]) begin
               if (cur_ff.a[0] || cur_ff.b[0]) begin
                  cur_in.a = alu_res.a >> 1;
                  cur_in.b = alu_res.b >> 1;
               end else begin
                  cur_in.a = cur_ff.a >> 1;
                  cur_in.b = cur_ff.b >> 1;
               end
               cur_in.g = cur_ff.g >> 1;
            end
            state_in = ST_SWAPCHK;
         end
         ST_SWAPCHK: begin
            // swap when tg is even or g has fallen below tg
            if (!tmp_ff.g[0] || alu_flags.borrow_g) begin
               cur_in = tmp_ff;
               tmp_in = cur_ff;
            end
            state_in = next_g[0] ? ST_FIX : ST_HALVE;
         end
         ST_FIX: begin
            if (alu_flags.borrow_a || alu_flags.borrow_b) begin
               state_in = ST_ADDFIX;
            end else begin
               cur_in   = alu_res;
               state_in = (tmp_ff.g != '0) ? ST_HALVE : ST_REDUCE;
            end
         end
         ST_ADDFIX: begin
            cur_in.a = alu_res.a;
            cur_in.b = alu_res.b;
            state_in = ST_FIX;
         end
         ST_REDUCE: begin
            if (!alu_flags.borrow_a && !alu_flags.borrow_b) begin
               cur_in.a = alu_res.a;
               cur_in.b = alu_res.b;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // restore the stripped factors of two, one per cycle
            if (k_ff != '0) begin
               cur_in.a = cur_ff.a << 1;
               cur_in.b = cur_ff.b << 1;
               cur_in.g = cur_ff.g << 1;
               k_in     = k_ff - bxg_pkg::KW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      big_ff   <= big_in;
      small_ff <= small_in;
      k_ff     <= k_in;
      cur_ff   <= cur_in;
      tmp_ff   <= tmp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

   always_comb begin
      rsp_data.coef_a        = cur_ff.a[bxg_pkg::WIDTH-1:0];
      rsp_data.coef_b        = cur_ff.b[bxg_pkg::WIDTH-1:0];
      rsp_data.gcd_value     = cur_ff.g[bxg_pkg::WIDTH-1:0];
      rsp_data.larger_value  = big_ff;
      rsp_data.smaller_value = small_ff;
   end

endmodule

// ----- hdl/bxg_alu.sv -----
module bxg_alu (
   input  bxg_pkg::alu_op_type op,
   input  bxg_pkg::opnd_type   x,
   input  bxg_pkg::opnd_type   y,
   output bxg_pkg::opnd_type   res,
   output bxg_pkg::flags_type  flags
);

   logic [bxg_pkg::IW:0] diff_a;
   logic [bxg_pkg::IW:0] diff_b;
   logic [bxg_pkg::IW:0] diff_g;

   // Subtract with one guard bit so the top bit is the borrow
   assign diff_a = {1'b0, x.a} - {1'b0, y.a};
   assign diff_b = {1'b0, x.b} - {1'b0, y.b};
   assign diff_g = {1'b0, x.g} - {1'b0, y.g};

   always_comb begin
      flags.borrow_a = diff_a[bxg_pkg::IW];
      flags.borrow_b = diff_b[bxg_pkg::IW];
      flags.borrow_g = diff_g[bxg_pkg::IW];
      case (op)
         bxg_pkg::ALU_ADD: begin
            res.a = x.a + y.a;
            res.b = x.b + y.b;
            res.g = x.g + y.g;
         end
         bxg_pkg::ALU_SUB: begin
            res.a = diff_a[bxg_pkg::IW-1:0];
            res.b = diff_b[bxg_pkg::IW-1:0];
            res.g = diff_g[bxg_pkg::IW-1:0];
         end
         default: begin
            res = x;
         end
      endcase
   end

endmodule
